// ===== hw/rtl/lzwe_pkg.sv =====
// Shared types and constants for the LZW encoder.
// No dependencies; the interfaces, the top level and the testbench refer to this package.
package lzwe_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned LITERALS  = 256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HCHK,
    ST_DCHK,
    ST_MISS,
    ST_LAST,
    ST_CLR
  } state_t;

endpackage

// ===== hw/rtl/lzwe_if.sv =====
// Valid/ready channel interfaces for the LZW encoder: byte input and code output.
// Depends on lzwe_pkg for the byte width.
interface lzwe_in_if;
  logic                           valid;
  logic                           ready;
  logic [lzwe_pkg::BYTE_BITS-1:0] symbol;
  logic                           end_of_message;

  modport source (output valid, output symbol, output end_of_message, input ready);
  modport sink (input valid, input symbol, input end_of_message, output ready);
endinterface

interface lzwe_out_if #(
  parameter int unsigned CODE_BITS = 12
);
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] code;
  logic                 last_code;

  modport source (output valid, output code, output last_code, input ready);
  modport sink (input valid, input code, input last_code, output ready);
endinterface

// ===== hw/rtl/lzw_encoder_top.sv =====
// LZW encoder: linear-probing hash index plus code-indexed dictionary; needs lzwe_pkg, lzwe_if.
// First byte of a message becomes the prefix. Other bytes read the hash index; each in-range
// slot is checked in the dictionary, a key mismatch probing the next slot, and a miss writes
// the new entry. One byte at a time. The final byte adds a final step; a full output queue
// stalls the miss and final steps. Reset is synchronous: control state and the output queue
// clear, then the hash index is zeroed with input held off; dictionary memory is never cleared.
module lzw_encoder_top #(
  parameter int unsigned CODE_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  lzwe_in_if.sink    in_chan,
  lzwe_out_if.source out_chan
);

  localparam int unsigned KEY_BITS   = CODE_BITS + lzwe_pkg::BYTE_BITS;
  localparam int unsigned ENTRY_BITS = KEY_BITS + CODE_BITS;
  localparam int unsigned DEPTH      = 2 ** CODE_BITS;
  localparam int unsigned PAD_BITS   = CODE_BITS - lzwe_pkg::BYTE_BITS;
  localparam logic [CODE_BITS:0]   CODE_LIMIT  = (CODE_BITS + 1)'(DEPTH);
  localparam logic [CODE_BITS:0]   FIRST_FREE  = (CODE_BITS + 1)'(lzwe_pkg::LITERALS);
  localparam logic [CODE_BITS-1:0] FIRST_ENTRY = CODE_BITS'(lzwe_pkg::LITERALS);
  localparam logic [CODE_BITS-1:0] LAST_SLOT   = CODE_BITS'(DEPTH - 1);

  lzwe_pkg::state_t state_r, state_nxt;

  logic [CODE_BITS-1:0]           prefix_r, prefix_nxt;
  logic                           pvalid_r, pvalid_nxt;
  logic [CODE_BITS:0]             nfc_r, nfc_nxt;
  logic [lzwe_pkg::BYTE_BITS-1:0] sym_r, sym_nxt;
  logic                           eom_r, eom_nxt;
  logic [CODE_BITS-1:0]           slot_r, slot_nxt;
  logic [CODE_BITS-1:0]           clr_r, clr_nxt;

  logic [CODE_BITS-1:0]  h_mem [DEPTH];
  logic [ENTRY_BITS-1:0] d_mem [DEPTH];
  logic [CODE_BITS-1:0]  h_rdata_r;
  logic [ENTRY_BITS-1:0] d_rdata_r;

  logic [CODE_BITS-1:0] fifo_code_r [2];
  logic                 fifo_last_r [2];
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic [1:0]           count_r, count_nxt;

  logic                 in_accept;
  logic                 pop;
  logic                 push;
  logic [CODE_BITS-1:0] push_code;
  logic                 push_last;
  logic                 dict_wr;
  logic                 clr_wr;
  logic                 fifo_room;
  logic                 dict_open;
  logic                 cand_in_range;
  logic                 slot_match;
  logic                 key_match;
  logic [KEY_BITS-1:0]  key;
  logic [CODE_BITS-1:0] hash;

  assign in_accept = in_chan.valid && in_chan.ready;
  assign pop       = out_chan.valid && out_chan.ready;
  assign fifo_room = (count_r != 2'd2);
  assign dict_open = (nfc_r < CODE_LIMIT);
  assign key       = {prefix_r, sym_r};
  assign hash      = prefix_r ^ {in_chan.symbol, {PAD_BITS{1'b0}}}
                   ^ CODE_BITS'(in_chan.symbol);

  // A slot is live only if its code was issued in this message and the
  // dictionary entry for that code points back at the same slot.
  assign cand_in_range = (h_rdata_r >= FIRST_ENTRY) && ({1'b0, h_rdata_r} < nfc_r);
  assign slot_match    = (d_rdata_r[ENTRY_BITS-1 -: CODE_BITS] == slot_r);
  assign key_match     = (d_rdata_r[KEY_BITS-1:0] == key);

  assign in_chan.ready      = (state_r == lzwe_pkg::ST_IDLE);
  assign out_chan.valid     = (count_r != 2'd0);
  assign out_chan.code      = fifo_code_r[rd_ptr_r];
  assign out_chan.last_code = fifo_last_r[rd_ptr_r];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lzwe_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (!pvalid_r) begin
            state_nxt = in_chan.end_of_message ? lzwe_pkg::ST_LAST : lzwe_pkg::ST_IDLE;
          end else begin
            state_nxt = lzwe_pkg::ST_HCHK;
          end
        end
      end
      lzwe_pkg::ST_HCHK: begin
        state_nxt = cand_in_range ? lzwe_pkg::ST_DCHK : lzwe_pkg::ST_MISS;
      end
      lzwe_pkg::ST_DCHK: begin
        if (slot_match && key_match) begin
          state_nxt = eom_r ? lzwe_pkg::ST_LAST : lzwe_pkg::ST_IDLE;
        end else if (slot_match) begin
          state_nxt = lzwe_pkg::ST_HCHK;
        end else begin
          state_nxt = lzwe_pkg::ST_MISS;
        end
      end
      lzwe_pkg::ST_MISS: begin
        if (fifo_room) begin
          state_nxt = eom_r ? lzwe_pkg::ST_LAST : lzwe_pkg::ST_IDLE;
        end
      end
      lzwe_pkg::ST_LAST: begin
        if (fifo_room) begin
          state_nxt = lzwe_pkg::ST_IDLE;
        end
      end
      lzwe_pkg::ST_CLR: begin
        if (clr_r == LAST_SLOT) begin
          state_nxt = lzwe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lzwe_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    prefix_nxt = prefix_r;
    pvalid_nxt = pvalid_r;
    nfc_nxt    = nfc_r;
    sym_nxt    = sym_r;
    eom_nxt    = eom_r;
    slot_nxt   = slot_r;
    clr_nxt    = clr_r;
    push       = 1'b0;
    push_code  = prefix_r;
    push_last  = 1'b0;
    dict_wr    = 1'b0;
    clr_wr     = 1'b0;
    case (state_r)
      lzwe_pkg::ST_IDLE: begin
        if (in_accept) begin
          sym_nxt = in_chan.symbol;
          eom_nxt = in_chan.end_of_message;
          if (!pvalid_r) begin
            prefix_nxt = CODE_BITS'(in_chan.symbol);
            pvalid_nxt = 1'b1;
          end else begin
            slot_nxt = hash;
          end
        end
      end
      lzwe_pkg::ST_HCHK: begin
      end
      lzwe_pkg::ST_DCHK: begin
        if (slot_match && key_match) begin
          prefix_nxt = h_rdata_r;
        end else if (slot_match) begin
          slot_nxt = slot_r + CODE_BITS'(1);
        end
      end
      lzwe_pkg::ST_MISS: begin
        if (fifo_room) begin
          push       = 1'b1;
          prefix_nxt = CODE_BITS'(sym_r);
          if (dict_open) begin
            dict_wr = 1'b1;
            nfc_nxt = nfc_r + (CODE_BITS + 1)'(1);
          end
        end
      end
      lzwe_pkg::ST_LAST: begin
        if (fifo_room) begin
          push       = 1'b1;
          push_last  = 1'b1;
          prefix_nxt = '0;
          pvalid_nxt = 1'b0;
          nfc_nxt    = FIRST_FREE;
        end
      end
      lzwe_pkg::ST_CLR: begin
        clr_wr  = 1'b1;
        clr_nxt = clr_r + CODE_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lzwe_pkg::ST_CLR;
      prefix_r <= '0;
      pvalid_r <= 1'b0;
      nfc_r    <= FIRST_FREE;
      clr_r    <= '0;
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      prefix_r <= prefix_nxt;
      pvalid_r <= pvalid_nxt;
      nfc_r    <= nfc_nxt;
      clr_r    <= clr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r  <= sym_nxt;
    eom_r  <= eom_nxt;
    slot_r <= slot_nxt;
    if (push) begin
      fifo_code_r[wr_ptr_r] <= push_code;
      fifo_last_r[wr_ptr_r] <= push_last;
    end
  end

  // New entries are written when a byte retires, so the next byte's first
  // read always sees them.
  always_ff @(posedge clk) begin
    if (clr_wr) begin
      h_mem[clr_r]                    <= '0;
    end else if (dict_wr) begin
      h_mem[slot_r]                   <= nfc_r[CODE_BITS-1:0];
    end
    if (dict_wr) begin
      d_mem[nfc_r[CODE_BITS-1:0]]     <= {slot_r, key};
    end
    h_rdata_r <= h_mem[slot_nxt];
    d_rdata_r <= d_mem[h_rdata_r];
  end

endmodule

// ===== hw/rtl/lzwe_checker.sv =====
// Port-level checks for the LZW encoder, attached to the top level by bind.
// Depends only on the top level's channel signals.
module lzwe_checker #(
  parameter int unsigned CODE_BITS = 12
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_eom,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CODE_BITS-1:0] out_code,
  input logic                 out_last
);

  // A stalled output word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_code) && $stable(out_last))
    else $error("output word changed while stalled");

  // Reset empties the output queue and holds the input off while the index clears.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("reset did not clear the encoder");

  // The final byte of a message always yields a code, so input must pause.
  a_eom_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_eom |=> !in_ready)
    else $error("input taken while the final code is pending");

endmodule

bind lzw_encoder_top lzwe_checker #(
  .CODE_BITS(CODE_BITS)
) u_lzwe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_eom    (in_chan.end_of_message),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_code  (out_chan.code),
  .out_last  (out_chan.last_code)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for lzw_encoder_top: drives byte words and checks the emitted codes.
// Depends on lzwe_pkg, the channel interfaces in lzwe_if.sv and the lzw_encoder_top module.
// A directed table runs first, then one long message, then random messages.
module tb;

  localparam int unsigned CODE_BITS     = 12;
  localparam int unsigned CODE_LIMIT    = 1 << CODE_BITS;
  localparam int unsigned RANDOM_ITEMS  = 950;
  localparam int unsigned FILL_ITEMS    = 500;
  localparam int unsigned FULL_ITEMS    = 300;
  localparam int unsigned CYCLE_LIMIT   = 3000000;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned DIRECTED_ROWS = 23;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 last_code;
  } code_word_t;

  typedef struct packed {
    logic [lzwe_pkg::BYTE_BITS-1:0] symbol;
    logic                           end_of_message;
    logic                           typed;
    logic [1:0]                     n_words;
    code_word_t                     w0;
    code_word_t                     w1;
  } byte_row_t;

  logic clk;
  logic rst_n;

  lzwe_in_if in_chan ();
  lzwe_out_if #(.CODE_BITS(CODE_BITS)) out_chan ();

  lzw_encoder_top #(.CODE_BITS(CODE_BITS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  byte_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, 2'd1, '{12'd0, 1'b1}, '0},
    '{8'hFF, 1'b1, 1'b1, 2'd1, '{12'd255, 1'b1}, '0},
    '{8'h41, 1'b0, 1'b1, 2'd0, '0, '0},
    '{8'h41, 1'b0, 1'b1, 2'd1, '{12'h041, 1'b0}, '0},
    '{8'h41, 1'b1, 1'b1, 2'd1, '{12'd256, 1'b1}, '0},
    '{8'hA5, 1'b0, 1'b1, 2'd0, '0, '0},
    '{8'h5A, 1'b1, 1'b1, 2'd2, '{12'h0A5, 1'b0}, '{12'h05A, 1'b1}},
    '{8'h41, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'h42, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'h41, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'h42, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'h41, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'h42, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'h41, 1'b1, 1'b0, 2'd0, '0, '0},
    '{8'h80, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'h7F, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'h01, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'hFE, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'h80, 1'b1, 1'b0, 2'd0, '0, '0},
    '{8'hFF, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'hFF, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'hFF, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'hFF, 1'b1, 1'b0, 2'd0, '0, '0}
  };

  logic [CODE_BITS-1:0] phrase_code [bit [CODE_BITS+7:0]];
  logic [CODE_BITS-1:0] cur_prefix = '0;
  bit                   have_prefix = 1'b0;
  int unsigned          next_code = lzwe_pkg::LITERALS;

  code_word_t  pending_codes [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          no_idle = 1'b0;

  function automatic void compress_byte(input logic [7:0] b, input logic eom,
                                        output code_word_t res [2], output int unsigned nres);
    bit [CODE_BITS+7:0] key;
    nres = 0;
    res[0] = '0;
    res[1] = '0;
    if (!have_prefix) begin
      cur_prefix  = CODE_BITS'(b);
      have_prefix = 1'b1;
    end else begin
      key = {cur_prefix, b};
      if (phrase_code.exists(key)) begin
        cur_prefix = phrase_code[key];
      end else begin
        res[nres] = '{cur_prefix, 1'b0};
        nres = nres + 1;
        if (next_code < CODE_LIMIT) begin
          phrase_code[key] = CODE_BITS'(next_code);
          next_code = next_code + 1;
        end
        cur_prefix = CODE_BITS'(b);
      end
    end
    if (eom) begin
      res[nres] = '{cur_prefix, 1'b1};
      nres = nres + 1;
      cur_prefix  = '0;
      have_prefix = 1'b0;
      next_code   = lzwe_pkg::LITERALS;
      phrase_code.delete();
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_byte(input byte_row_t row);
    int unsigned gap;
    code_word_t  res [2];
    int unsigned nres;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.symbol         <= row.symbol;
    in_chan.end_of_message <= row.end_of_message;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    compress_byte(row.symbol, row.end_of_message, res, nres);
    if (row.typed) begin
      nres   = row.n_words;
      res[0] = row.w0;
      res[1] = row.w1;
    end
    for (int unsigned i = 0; i < nres; i++) pending_codes.push_back(res[i]);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_chan.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    code_word_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected code word: code %0d last_code %0b",
                   out_chan.code, out_chan.last_code);
      end else begin
        want = pending_codes.pop_front();
        if (want.code !== out_chan.code || want.last_code !== out_chan.last_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected code %0d last %0b, got code %0d last %0b",
                     want.code, want.last_code, out_chan.code, out_chan.last_code);
        end
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 7);
    end
  end

  initial begin
    int unsigned random_items;
    int unsigned len;
    int unsigned kind;
    int unsigned span;
    int unsigned period;
    logic [7:0]  base;
    logic [7:0]  pattern [4];
    logic [7:0]  b;
    rst_n                  = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.symbol         = '0;
    in_chan.end_of_message = 1'b0;
    out_chan.ready         = 1'b0;
    random_items           = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) send_byte(directed_rows[i]);

    // One long message: uniform bytes first, then a small alphabet that mostly
    // extends entries already in the dictionary.
    for (int unsigned i = 0; i < FILL_ITEMS + FULL_ITEMS; i++) begin
      if (i < FILL_ITEMS) b = 8'($urandom_range(0, 255));
      else b = 8'h61 + 8'($urandom_range(0, 2));
      no_idle = (i % 512) < 64;
      send_byte('{b, 1'(i == FILL_ITEMS + FULL_ITEMS - 1), 1'b0, 2'd0, '0, '0});
    end

    while (random_items < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: len = 1;
        1: len = $urandom_range(60, 200);
        default: len = $urandom_range(2, 40);
      endcase
      kind   = $urandom_range(0, 2);
      base   = 8'($urandom_range(0, 255));
      span   = $urandom_range(1, 3);
      period = $urandom_range(1, 4);
      for (int k = 0; k < 4; k++) pattern[k] = 8'($urandom_range(0, 255));
      for (int unsigned i = 0; i < len; i++) begin
        case (kind)
          0: b = 8'($urandom_range(0, 255));
          1: b = base + 8'($urandom_range(0, span));
          default: b = pattern[i % period];
        endcase
        send_byte('{b, 1'(i == len - 1), 1'b0, 2'd0, '0, '0});
        random_items++;
      end
    end

    in_chan.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lzwe_pkg.sv
hw/rtl/lzwe_if.sv
hw/rtl/lzw_encoder_top.sv
hw/rtl/lzwe_checker.sv
tb/sv/tb.sv
